### sv/sic_pkg.sv
`timescale 1ns / 1ps
// Shared sizes and widths for the sequence inversion counter.
// Depends on nothing; used by sequence_inversion_counter_unit.
package sic_pkg;

  // Capacity of the element store (legal range 2 to 4096).
  localparam int MaxLen   = 256;
  localparam int IDX_W    = $clog2(MaxLen);
  localparam int CNT_W    = $clog2(MaxLen + 1);

  localparam int VALUE_W  = 32;
  localparam int TOTAL_W  = 15;
  localparam int SUM_W    = ((CNT_W > TOTAL_W) ? CNT_W : TOTAL_W) + 1;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [CNT_W-1:0]   FILL_FULL = CNT_W'(MaxLen);

  // Result fields, highest bit first.
  typedef struct packed {
    logic               too_long;
    logic [TOTAL_W-1:0] inversions;
  } result_t;

endpackage

### sv/sequence_inversion_counter_unit.sv
`timescale 1ns / 1ps
// Inversion counter: one shared compare unit sweeps the element store per item.
// Depends on sic_pkg for sizes and the result layout.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  in_     | input     | in_tvalid/tready   | tdata[31:0] value (signed), tlast last
//  out_    | output    | out_tvalid/tready  | tdata[14:0] inversions, tdata[15] too_long
//
// Steps for a stored item: accept, one read per stored element, a compare of the last
// word, an exit and a store write (with an empty store: accept, exit, store write).
// A last item adds an emit step; a full store only flags the item (then emits if last).
// Reset: clear sequencer, fill count, total, flag and output valid; the store is not cleared.
// Stalls: a waiting result sits in the output register while new transactions are taken;
// a later last item holds in the emit state until that register is free.

module sequence_inversion_counter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sic_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sic_pkg::OUT_DATA_W-1:0] out_tdata   // [14:0] inversions, [15] too_long
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_EMIT
  } state_t;

  state_t                           state_r, state_nxt;
  logic [sic_pkg::VALUE_W-1:0]      key_r, key_nxt;
  logic                             last_r, last_nxt;
  logic [sic_pkg::CNT_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                             pend_r, pend_nxt;
  logic [sic_pkg::CNT_W-1:0]        greater_r, greater_nxt;
  logic [sic_pkg::CNT_W-1:0]        fill_r, fill_nxt;
  logic [sic_pkg::TOTAL_W-1:0]      total_r, total_nxt;
  logic                             ovf_r, ovf_nxt;
  logic                             out_valid_r, out_valid_nxt;
  sic_pkg::result_t                 out_data_r, out_data_nxt;

  // Element store: keys held with the sign bit flipped so unsigned compare
  // gives signed order.
  logic [sic_pkg::VALUE_W-1:0]      mem [sic_pkg::MaxLen];
  logic [sic_pkg::VALUE_W-1:0]      rd_data_r;
  logic                             mem_we;
  logic [sic_pkg::SUM_W-1:0]        sum;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Running total plus this element's count; saturated in ST_FINISH.
  assign sum = sic_pkg::SUM_W'(total_r) + sic_pkg::SUM_W'(greater_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[sic_pkg::IDX_W-1:0]] <= key_r;
    end
    rd_data_r <= mem[rd_idx_r[sic_pkg::IDX_W-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    last_nxt      = last_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = 1'b0;
    greater_nxt   = greater_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;

    // Drop the result once the sink takes it.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          key_nxt     = in_tdata ^ {1'b1, {(sic_pkg::VALUE_W-1){1'b0}}};
          last_nxt    = in_tlast;
          rd_idx_nxt  = '0;
          greater_nxt = '0;
          if (fill_r == sic_pkg::FILL_FULL) begin
            // Store full: neither store nor count, just flag it.
            ovf_nxt   = 1'b1;
            state_nxt = in_tlast ? ST_EMIT : ST_IDLE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle; compare the data that returns in the next cycle.
        if (rd_idx_r != fill_r) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          pend_nxt   = 1'b1;
        end
        if (pend_r && (rd_data_r > key_r)) begin
          greater_nxt = greater_r + 1'b1;
        end
        if ((rd_idx_r == fill_r) && !pend_r) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (sum > sic_pkg::SUM_W'(sic_pkg::TOTAL_MAX)) begin
          total_nxt = sic_pkg::TOTAL_MAX;
        end else begin
          total_nxt = sum[sic_pkg::TOTAL_W-1:0];
        end
        mem_we    = 1'b1;
        fill_nxt  = fill_r + 1'b1;
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end

      ST_EMIT: begin
        // Hold until the output register is free, then load it and clear.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.inversions = total_r;
          out_data_nxt.too_long   = ovf_r;
          fill_nxt                = '0;
          total_nxt               = '0;
          ovf_nxt                 = 1'b0;
          state_nxt               = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      fill_r      <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r      <= key_nxt;
    last_r     <= last_nxt;
    rd_idx_r   <= rd_idx_nxt;
    greater_r  <= greater_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
